### rtl/cds_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cds_pkg;

   // Widths of the shared datapath.
   localparam int WIDE_W     = 48;
   localparam int HALF_W     = 24;
   localparam int ACC_W      = 96;
   localparam int DIV_NUM_W  = 64;
   localparam int DIV_DEN_W  = 52;
   localparam int QUOT_W     = 32;
   localparam int DATA_W     = 32;

   // Constants held with 32 fraction bits.
   localparam logic [63:0] TWO_LN2_Q32 = 64'd5954088944;
   localparam logic [63:0] K048_Q32    = 64'd2061584302;
   localparam logic [63:0] K0235_Q32   = 64'd1009317315;

   localparam logic signed [WIDE_W-1:0] WIDE_MAX = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [WIDE_W-1:0] WIDE_MIN = 48'sh8000_0000_0000;

   typedef struct packed {
      logic                     start;
      logic signed [WIDE_W-1:0] a;
      logic signed [WIDE_W-1:0] b;
   } mul_req_type;

   typedef struct packed {
      logic                     done;
      logic signed [WIDE_W-1:0] res;
   } mul_rsp_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] dividend;
      logic [DIV_DEN_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [QUOT_W-1:0] quot;
   } div_rsp_type;

   function automatic logic signed [WIDE_W-1:0] sat_wide(input logic signed [WIDE_W:0] s);
      logic signed [WIDE_W-1:0] r;
      if (s[WIDE_W] != s[WIDE_W-1]) begin
         r = s[WIDE_W] ? WIDE_MIN : WIDE_MAX;
      end else begin
         r = s[WIDE_W-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [WIDE_W-1:0] sat_add(input logic signed [WIDE_W-1:0] a,
                                                        input logic signed [WIDE_W-1:0] b);
      logic signed [WIDE_W:0] s;
      s = (WIDE_W+1)'(a) + (WIDE_W+1)'(b);
      return sat_wide(s);
   endfunction

   function automatic logic signed [WIDE_W-1:0] sat_sub(input logic signed [WIDE_W-1:0] a,
                                                        input logic signed [WIDE_W-1:0] b);
      logic signed [WIDE_W:0] s;
      s = (WIDE_W+1)'(a) - (WIDE_W+1)'(b);
      return sat_wide(s);
   endfunction

   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W:0] s);
      logic [WIDE_W-DATA_W+1:0] hi;
      logic signed [DATA_W-1:0] r;
      hi = s[WIDE_W:DATA_W-1];
      if (hi == '0 || hi == '1) begin
         r = s[DATA_W-1:0];
      end else if (s[WIDE_W]) begin
         r = 32'sh8000_0000;
      end else begin
         r = 32'sh7FFF_FFFF;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### rtl/cds_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface cds_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] target;
   logic [19:0]        time_step;

   modport source (output valid, output target, output time_step, input ready);
   modport sink (input valid, input target, input time_step, output ready);
endinterface

`default_nettype wire

### rtl/cds_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface cds_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] new_position;
   logic signed [31:0] new_velocity;

   modport source (output valid, output new_position, output new_velocity, input ready);
   modport sink (input valid, input new_position, input new_velocity, output ready);
endinterface

`default_nettype wire

### rtl/cds_mul.sv
`timescale 1ns / 1ps
`default_nettype none

// Signed 48 by 48 fixed-point multiply on one 24 by 24 multiplier, four partial
// products, rounded to nearest (ties away from zero) and saturated.
module cds_mul
   import cds_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  wire         clock,
   input  wire         reset,
   input  mul_req_type req,
   output mul_rsp_type rsp
);

   localparam logic [ACC_W-1:0] RND = ACC_W'(1) << (FRAC_BITS - 1);
   localparam logic [ACC_W-1:0] BIG = ACC_W'(1) << (WIDE_W - 1);

   logic              busy_ff, fin_ff, done_ff;
   logic [1:0]        cnt_ff;
   logic [WIDE_W-1:0] ma_ff, mb_ff, ma_in, mb_in;
   logic              neg_ff;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [WIDE_W-1:0] res_ff, res_in;

   logic [HALF_W-1:0] a_half, b_half;
   logic [WIDE_W-1:0] pp;
   logic [ACC_W-1:0]  pp_sh, mag_full;
   logic [WIDE_W-1:0] mag;

   assign ma_in = req.a[WIDE_W-1] ? WIDE_W'(-req.a) : WIDE_W'(req.a);
   assign mb_in = req.b[WIDE_W-1] ? WIDE_W'(-req.b) : WIDE_W'(req.b);

   always_comb begin
      a_half = cnt_ff[0] ? ma_ff[WIDE_W-1:HALF_W] : ma_ff[HALF_W-1:0];
      b_half = cnt_ff[1] ? mb_ff[WIDE_W-1:HALF_W] : mb_ff[HALF_W-1:0];
      pp     = a_half * b_half;
      unique case (cnt_ff)
         2'd0:    pp_sh = ACC_W'(pp);
         2'd3:    pp_sh = ACC_W'(pp) << (2 * HALF_W);
         default: pp_sh = ACC_W'(pp) << HALF_W;
      endcase
      acc_in = acc_ff + pp_sh;
   end

   always_comb begin
      mag_full = acc_ff >> FRAC_BITS;
      mag      = (mag_full > BIG) ? WIDE_W'(BIG) : mag_full[WIDE_W-1:0];
      if (neg_ff) begin
         res_in = -$signed(mag);
      end else if (mag[WIDE_W-1]) begin
         res_in = WIDE_MAX;
      end else begin
         res_in = $signed(mag);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         done_ff <= fin_ff;
         fin_ff  <= busy_ff && (cnt_ff == 2'd3);
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 2'd0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 2'd1;
            if (cnt_ff == 2'd3) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         ma_ff  <= ma_in;
         mb_ff  <= mb_in;
         neg_ff <= req.a[WIDE_W-1] ^ req.b[WIDE_W-1];
         acc_ff <= RND;
      end else if (busy_ff) begin
         acc_ff <= acc_in;
      end
      if (fin_ff) begin
         res_ff <= res_in;
      end
   end

   assign rsp.done = done_ff;
   assign rsp.res  = res_ff;

endmodule

`default_nettype wire

### rtl/cds_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Unsigned restoring divider, one quotient bit per cycle, 32 quotient bits.
// A quotient that would not fit in 32 bits comes back as all ones.
module cds_div
   import cds_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic                 busy_ff, done_ff;
   logic [4:0]           cnt_ff;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in, dvs_ff;
   logic [QUOT_W-1:0]    quo_ff, quo_in;
   logic [DIV_DEN_W:0]   trial;
   logic                 ge;
   logic [DIV_DEN_W-1:0] hi_ext;
   logic                 sat;

   assign hi_ext = DIV_DEN_W'(req.dividend[DIV_NUM_W-1:QUOT_W]);
   assign sat    = (hi_ext >= req.divisor);

   always_comb begin
      trial  = {rem_ff, quo_ff[QUOT_W-1]};
      ge     = (trial >= {1'b0, dvs_ff});
      rem_in = ge ? DIV_DEN_W'(trial - {1'b0, dvs_ff}) : trial[DIV_DEN_W-1:0];
      quo_in = {quo_ff[QUOT_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 5'd0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= !sat;
            done_ff <= sat;
            cnt_ff  <= 5'd0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         dvs_ff <= req.divisor;
         rem_ff <= hi_ext;
         quo_ff <= sat ? '1 : req.dividend[QUOT_W-1:0];
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign rsp.done = done_ff;
   assign rsp.quot = quo_ff;

endmodule

`default_nettype wire

### rtl/critically_damped_spring_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Critically damped spring smoother. Each request beat carries a target and a time
// step; the block moves its kept position and velocity one step of a critically
// damped spring toward the target and returns the new position and velocity as one
// response beat, all in signed fixed point with FRAC_BITS fraction bits, saturated to
// 32 bits. The spring half-life sits in the register at byte address 0 (reset 1.0).
// A sequencer runs the update on one shared 24 by 24 multiplier for the 48-bit
// products and one shared bit-serial divider. Eleven products and one division make
// up each item, and the next request beat is accepted once the response has moved
// to its register. The damping factor needs a second division, done only for the
// first item after reset or after a half-life write, and cut short when that
// quotient saturates. The request side is ready only while the sequencer is idle.
// A finished response waits in its own register, so the next item can be accepted
// and worked on while the previous response is not yet taken.
module critically_damped_spring_top
   import cds_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  wire         clock,
   input  wire         reset,
   cds_req_if.sink     req_bus,
   cds_rsp_if.source   rsp_bus,
   input  wire         psel,
   input  wire         penable,
   input  wire         pwrite,
   input  wire  [2:0]  paddr,
   input  wire  [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam logic REG_HALF_LIFE = 1'b0;

   localparam int NUM_SH = (2 * FRAC_BITS >= 32) ? 2 * FRAC_BITS - 32 : 0;
   localparam int DEN_SH = (2 * FRAC_BITS >= 32) ? 0 : 32 - 2 * FRAC_BITS;
   localparam logic [63:0] Y_NUM  = TWO_LN2_Q32 << NUM_SH;
   localparam logic [63:0] E_NUM  = 64'd1 << (2 * FRAC_BITS);
   localparam logic [63:0] K48_Q  = (K048_Q32 + (64'd1 << (31 - FRAC_BITS)))
                                    >> (32 - FRAC_BITS);
   localparam logic [63:0] K235_Q = (K0235_Q32 + (64'd1 << (31 - FRAC_BITS)))
                                    >> (32 - FRAC_BITS);
   localparam logic [WIDE_W-1:0] ONE_Q = WIDE_W'(1) << FRAC_BITS;

   typedef enum logic [1:0] {
      S_IDLE,
      S_ISSUE,
      S_WAIT,
      S_OUT
   } state_type;

   // One entry per use of a shared unit, in the order the update needs them.
   typedef enum logic [3:0] {
      STEP_YDIV,
      STEP_J1,
      STEP_U,
      STEP_U2,
      STEP_U3,
      STEP_D2,
      STEP_D3,
      STEP_EDIV,
      STEP_PX,
      STEP_W,
      STEP_PV,
      STEP_NX,
      STEP_NV
   } step_type;

   state_type state_ff;
   step_type  step_ff;

   logic [31:0]              half_life_ff;
   logic                     y_ok_ff;
   logic [31:0]              y_ff;
   logic signed [31:0]       pos_ff, vel_ff, goal_ff;
   logic [19:0]              dt_ff;
   logic signed [32:0]       j0_ff;
   logic signed [WIDE_W-1:0] j1_ff, u_ff, u2_ff, u3_ff, d_ff, px_ff, w_ff, pv_ff;
   logic [31:0]              e_ff;
   logic signed [31:0]       nx_ff, nv_ff;
   logic                     rsp_valid_ff;
   logic signed [31:0]       rsp_pos_ff, rsp_vel_ff;

   mul_req_type mul_req;
   mul_rsp_type mul_rsp;
   div_req_type div_req;
   div_rsp_type div_rsp;

   logic                     step_is_div;
   logic                     unit_done;
   logic                     cfg_write;
   logic                     rsp_load;
   logic [63:0]              y_den, d_u;
   logic signed [WIDE_W-1:0] y_w, dt_w, j0_w, vel_w, m;

   cds_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
      .clock (clock),
      .reset (reset),
      .req   (mul_req),
      .rsp   (mul_rsp)
   );

   cds_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // Register port: one half-life register, always ready, read back as written.
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_HALF_LIFE);
   assign prdata    = (paddr[2] == REG_HALF_LIFE) ? half_life_ff : 32'd0;

   assign req_bus.ready        = (state_ff == S_IDLE);
   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.new_position = rsp_pos_ff;
   assign rsp_bus.new_velocity = rsp_vel_ff;

   // The finished result moves to the response register once that is free or
   // its beat is taken at this edge.
   assign rsp_load = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_bus.ready);

   // Operands widened to the 48-bit working format.
   assign y_w   = WIDE_W'(y_ff);
   assign dt_w  = WIDE_W'(dt_ff);
   assign j0_w  = WIDE_W'(j0_ff);
   assign vel_w = WIDE_W'(vel_ff);
   assign m     = mul_rsp.res;

   // Damping divides 2*ln2 by the half-life plus one LSB, rounded to nearest.
   // The decay factor divides one by the rational denominator, also rounded.
   assign y_den = (64'(half_life_ff) + 64'd1) << DEN_SH;
   assign d_u   = 64'($unsigned(d_ff));

   assign step_is_div = (step_ff == STEP_YDIV) || (step_ff == STEP_EDIV);
   assign unit_done   = step_is_div ? div_rsp.done : mul_rsp.done;

   always_comb begin
      mul_req = '0;
      div_req = '0;
      unique case (step_ff)
         STEP_YDIV: begin
            div_req.dividend = Y_NUM + (y_den >> 1);
            div_req.divisor  = y_den[DIV_DEN_W-1:0];
         end
         STEP_EDIV: begin
            div_req.dividend = E_NUM + (d_u >> 1);
            div_req.divisor  = d_u[DIV_DEN_W-1:0];
         end
         STEP_J1: begin
            mul_req.a = j0_w;
            mul_req.b = y_w;
         end
         STEP_U: begin
            mul_req.a = y_w;
            mul_req.b = dt_w;
         end
         STEP_U2: begin
            mul_req.a = u_ff;
            mul_req.b = u_ff;
         end
         STEP_U3: begin
            mul_req.a = u2_ff;
            mul_req.b = u_ff;
         end
         STEP_D2: begin
            mul_req.a = WIDE_W'(K48_Q);
            mul_req.b = u2_ff;
         end
         STEP_D3: begin
            mul_req.a = WIDE_W'(K235_Q);
            mul_req.b = u3_ff;
         end
         STEP_PX: begin
            mul_req.a = j1_ff;
            mul_req.b = dt_w;
         end
         STEP_W: begin
            mul_req.a = j1_ff;
            mul_req.b = y_w;
         end
         STEP_PV: begin
            mul_req.a = w_ff;
            mul_req.b = dt_w;
         end
         STEP_NX: begin
            mul_req.a = WIDE_W'(e_ff);
            mul_req.b = px_ff;
         end
         STEP_NV: begin
            mul_req.a = WIDE_W'(e_ff);
            mul_req.b = pv_ff;
         end
         default: begin
            mul_req.a = '0;
         end
      endcase
      mul_req.start = (state_ff == S_ISSUE) && !step_is_div;
      div_req.start = (state_ff == S_ISSUE) && step_is_div;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= STEP_YDIV;
         half_life_ff <= 32'h0001_0000;
         y_ok_ff      <= 1'b0;
         pos_ff       <= '0;
         vel_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (req_bus.valid) begin
                  goal_ff  <= req_bus.target;
                  dt_ff    <= req_bus.time_step;
                  j0_ff    <= 33'(pos_ff) - 33'(req_bus.target);
                  step_ff  <= y_ok_ff ? STEP_J1 : STEP_YDIV;
                  state_ff <= S_ISSUE;
               end
            end
            S_ISSUE: begin
               state_ff <= S_WAIT;
            end
            S_WAIT: begin
               if (unit_done) begin
                  // The last product ends the sequence; every other step issues the next.
                  if (step_ff == STEP_NV) begin
                     state_ff <= S_OUT;
                  end else begin
                     state_ff <= S_ISSUE;
                  end
                  unique case (step_ff)
                     STEP_YDIV: begin
                        y_ff    <= div_rsp.quot;
                        y_ok_ff <= 1'b1;
                        step_ff <= STEP_J1;
                     end
                     STEP_J1: begin
                        j1_ff   <= sat_add(vel_w, m);
                        step_ff <= STEP_U;
                     end
                     STEP_U: begin
                        u_ff    <= m;
                        step_ff <= STEP_U2;
                     end
                     STEP_U2: begin
                        u2_ff   <= m;
                        step_ff <= STEP_U3;
                     end
                     STEP_U3: begin
                        u3_ff   <= m;
                        step_ff <= STEP_D2;
                     end
                     STEP_D2: begin
                        d_ff    <= sat_add(sat_add(ONE_Q, u_ff), m);
                        step_ff <= STEP_D3;
                     end
                     STEP_D3: begin
                        d_ff    <= sat_add(d_ff, m);
                        step_ff <= STEP_EDIV;
                     end
                     STEP_EDIV: begin
                        e_ff    <= div_rsp.quot;
                        step_ff <= STEP_PX;
                     end
                     STEP_PX: begin
                        px_ff   <= sat_add(j0_w, m);
                        step_ff <= STEP_W;
                     end
                     STEP_W: begin
                        w_ff    <= m;
                        step_ff <= STEP_PV;
                     end
                     STEP_PV: begin
                        pv_ff   <= sat_sub(vel_w, m);
                        step_ff <= STEP_NX;
                     end
                     STEP_NX: begin
                        nx_ff   <= sat32((WIDE_W+1)'(m) + (WIDE_W+1)'(goal_ff));
                        step_ff <= STEP_NV;
                     end
                     STEP_NV: begin
                        nv_ff   <= sat32((WIDE_W+1)'(m));
                     end
                     default: begin
                        step_ff <= STEP_YDIV;
                     end
                  endcase
               end
            end
            S_OUT: begin
               if (rsp_load) begin
                  rsp_pos_ff <= nx_ff;
                  rsp_vel_ff <= nv_ff;
                  pos_ff     <= nx_ff;
                  vel_ff     <= nv_ff;
                  state_ff   <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase

         // A new half-life invalidates the cached damping factor.
         if (cfg_write) begin
            half_life_ff <= pwdata;
            y_ok_ff      <= 1'b0;
         end
      end
   end

endmodule

`default_nettype wire

### dv/critically_damped_spring_checker.sv
`timescale 1ns / 1ps

// Watches the request, response and register ports of the spring smoother, keeps
// its own copy of the spring state, and compares every response beat with the
// oldest prediction.
module critically_damped_spring_checker #(
   parameter int FRAC_BITS = 16
) (
   input  wire        clock,
   input  wire        reset,
   cds_req_if         req_mon,
   cds_rsp_if         rsp_mon,
   input  wire        psel,
   input  wire        penable,
   input  wire        pwrite,
   input  wire  [2:0] paddr,
   input  wire [31:0] pwdata,
   input  wire        pready,
   output int         failures,
   output int         outstanding,
   output int         compared
);

   localparam int HALF_LIFE_INDEX = 0;
   localparam logic [31:0] HALF_LIFE_RESET = 32'h0001_0000;

   // 2*ln2, 0.48 and 0.235 with 32 fraction bits.
   localparam logic [63:0] RATE_NUM_Q32  = 64'd5954088944;
   localparam logic [63:0] QUAD_COEF_Q32 = 64'd2061584302;
   localparam logic [63:0] CUBE_COEF_Q32 = 64'd1009317315;

   localparam longint WIDE_HI = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint WIDE_LO = -64'sh0000_8000_0000_0000;

   typedef struct packed {
      logic signed [31:0] position;
      logic signed [31:0] velocity;
   } spring_out_type;

   spring_out_type predicted_moves[$];
   logic [31:0] half_life;
   longint      spring_pos;
   longint      spring_vel;
   int          fail_total;
   int          beats_seen;

   function automatic longint clamp48(longint a);
      if (a > WIDE_HI) return WIDE_HI;
      if (a < WIDE_LO) return WIDE_LO;
      return a;
   endfunction

   function automatic logic signed [31:0] clamp32(longint a);
      if (a > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (a < -64'sd2147483648) return 32'sh8000_0000;
      return a[31:0];
   endfunction

   function automatic longint coef(logic [63:0] k);
      return longint'((k + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS));
   endfunction

   // Product rounded to nearest with ties away from zero, saturated to 48 bits.
   function automatic longint fx_mul(longint a, longint b);
      logic         neg;
      logic [63:0]  ma;
      logic [63:0]  mb;
      logic [127:0] mag;
      neg = (a < 0) != (b < 0);
      ma  = (a < 0) ? -a : a;
      mb  = (b < 0) ? -b : b;
      mag = (128'(ma) * 128'(mb) + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
      if (mag > 128'h8000_0000_0000) mag = 128'h8000_0000_0000;
      if (neg) return -longint'(mag[63:0]);
      if (mag > 128'h7FFF_FFFF_FFFF) mag = 128'h7FFF_FFFF_FFFF;
      return longint'(mag[63:0]);
   endfunction

   function automatic longint damping_rate(logic [31:0] h);
      logic [127:0] num;
      logic [127:0] den;
      logic [127:0] q;
      if (2 * FRAC_BITS >= 32) begin
         num = 128'(RATE_NUM_Q32) << (2 * FRAC_BITS - 32);
         den = 128'(h) + 128'd1;
      end else begin
         num = 128'(RATE_NUM_Q32);
         den = (128'(h) + 128'd1) << (32 - 2 * FRAC_BITS);
      end
      q = (num + den / 2) / den;
      if (q > 128'hFFFF_FFFF) q = 128'hFFFF_FFFF;
      return longint'(q[63:0]);
   endfunction

   // Cubic rational stand-in for exp(-u); u is never negative here.
   function automatic longint decay(longint u);
      longint u2;
      longint u3;
      longint d;
      u2 = fx_mul(u, u);
      u3 = fx_mul(u2, u);
      d  = clamp48((longint'(1) << FRAC_BITS) + u);
      d  = clamp48(d + fx_mul(coef(QUAD_COEF_Q32), u2));
      d  = clamp48(d + fx_mul(coef(CUBE_COEF_Q32), u3));
      return ((longint'(1) << (2 * FRAC_BITS)) + d / 2) / d;
   endfunction

   function automatic spring_out_type spring_step(longint goal, longint dt);
      spring_out_type r;
      longint         y;
      longint         j0;
      longint         j1;
      longint         e;
      longint         px;
      longint         pv;
      y  = damping_rate(half_life);
      j0 = spring_pos - goal;
      j1 = clamp48(spring_vel + fx_mul(j0, y));
      e  = decay(fx_mul(y, dt));
      px = clamp48(j0 + fx_mul(j1, dt));
      pv = clamp48(spring_vel - fx_mul(fx_mul(j1, y), dt));
      r.position = clamp32(fx_mul(e, px) + goal);
      r.velocity = clamp32(fx_mul(e, pv));
      spring_pos = longint'(r.position);
      spring_vel = longint'(r.velocity);
      return r;
   endfunction

   task automatic report(string msg);
      fail_total++;
      if (fail_total <= 10) $display("%s", msg);
   endtask

   always @(posedge clock) begin : scoreboard
      spring_out_type want;
      if (reset) begin
         predicted_moves.delete();
         half_life  = HALF_LIFE_RESET;
         spring_pos = 0;
         spring_vel = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (predicted_moves.size() == 0) begin
               report($sformatf("Response beat with nothing pending: position %0d velocity %0d",
                                rsp_mon.new_position, rsp_mon.new_velocity));
            end else begin
               want = predicted_moves.pop_front();
               beats_seen++;
               if (rsp_mon.new_position !== want.position)
                  report($sformatf("Beat %0d new_position: expected %0d, got %0d",
                                   beats_seen, want.position, rsp_mon.new_position));
               if (rsp_mon.new_velocity !== want.velocity)
                  report($sformatf("Beat %0d new_velocity: expected %0d, got %0d",
                                   beats_seen, want.velocity, rsp_mon.new_velocity));
            end
         end
         if (req_mon.valid && req_mon.ready)
            predicted_moves.insert(predicted_moves.size(),
                                   spring_step(longint'(req_mon.target),
                                               longint'(req_mon.time_step)));
         if (psel && penable && pwrite && pready && (paddr >> 2) == HALF_LIFE_INDEX)
            half_life = pwdata;
      end
      failures    <= fail_total;
      outstanding <= predicted_moves.size();
      compared    <= beats_seen;
   end

endmodule

### dv/critically_damped_spring_top_test.sv
`timescale 1ns / 1ps

// Top of the spring smoother bench. This module only produces stimulus: request
// beats, response back-pressure and half-life writes. All prediction and comparison
// lives in the checker, which reports its failure count and the number of responses
// still owed back to this module for the final verdict.
module critically_damped_spring_top_test;

   // Register byte addresses. Only the half-life register exists; the second address
   // is unmapped and a write there must leave the spring untouched.
   localparam logic [2:0] REG_HALF_LIFE = 3'd0;
   localparam logic [2:0] REG_UNMAPPED  = 3'd4;

   // Each item can be preceded by a random request gap and followed by random response
   // stalls. This limit leaves several times the slowest correct run.
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int PHASE_ITEMS  = 200;
   localparam int PHASE_COUNT  = 7;
   localparam int SETTLE_WAIT  = 150;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;
   logic        sink_ready = 1'b0;
   int          stall_left = 0;
   int          req_gap_max = 4;
   int          rsp_stall_max = 4;
   int          items_sent = 0;
   int          reg_writes = 0;
   int          cycle_count = 0;
   int          failures;
   int          outstanding;
   int          compared;

   cds_req_if req_link();
   cds_rsp_if rsp_link();

   assign rsp_link.ready = sink_ready;

   critically_damped_spring_top #(.FRAC_BITS(16)) uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_link),
      .rsp_bus (rsp_link),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   critically_damped_spring_checker #(.FRAC_BITS(16)) spring_check (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_link),
      .rsp_mon     (rsp_link),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .pready      (pready),
      .failures    (failures),
      .outstanding (outstanding),
      .compared    (compared)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // The run is cut off here if the block stops making progress.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d responses owed", cycle_count,
                  outstanding);
         $display("Test completed with failures");
         $finish;
      end
   end

   // Response back-pressure. After every accepted beat a fresh stall length is drawn;
   // zero keeps ready high so back-to-back beats are also exercised.
   always @(posedge clock) begin : rsp_pacing
      int n;
      if (reset) begin
         sink_ready <= 1'b0;
         stall_left <= 0;
      end else if (sink_ready && rsp_link.valid) begin
         n = $urandom_range(0, rsp_stall_max);
         if (n != 0) begin
            sink_ready <= 1'b0;
            stall_left <= n;
         end
      end else if (!sink_ready) begin
         if (stall_left <= 1) begin
            sink_ready <= 1'b1;
            stall_left <= 0;
         end else begin
            stall_left <= stall_left - 1;
         end
      end
   end

   // Sends one request beat after a random gap. Valid is lowered only when a gap is
   // drawn, so an item that follows directly keeps valid high across the edge.
   task automatic spring_move(input logic signed [31:0] goal, input logic [19:0] dt);
      int gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap != 0) begin
         req_link.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_link.valid     <= 1'b1;
      req_link.target    <= goal;
      req_link.time_step <= dt;
      do @(posedge clock); while (!req_link.ready);
      items_sent++;
   endtask

   // Stops sending and waits until the checker has seen every owed response. The
   // first edge lets the count pick up an item accepted at the current edge.
   task automatic wait_drained();
      req_link.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // One register write: a setup phase, then an access phase that completes on pready.
   task automatic write_register(input logic [2:0] addr, input logic [31:0] value);
      wait_drained();
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      reg_writes++;
   endtask

   // Most items look like a real animation loop: a target that wanders within 16 units
   // either way and a frame time of up to an eighth of a second. The rest is wider
   // noise, partly over the full field ranges, and the corner values that drive the
   // datapath into saturation.
   task automatic random_move();
      logic signed [31:0] goal;
      logic [19:0]        dt;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: begin
            goal = 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
            dt   = 20'($urandom_range(0, 32'h2000));
         end
         6: begin
            goal = $urandom();
            dt   = 20'($urandom());
         end
         7: begin
            case ($urandom_range(0, 3))
               0: goal = 32'sh7FFF_FFFF;
               1: goal = 32'sh8000_0000;
               2: goal = 32'sh0000_0000;
               default: goal = 32'shFFFF_FFFF;
            endcase
            case ($urandom_range(0, 2))
               0: dt = 20'h0_0000;
               1: dt = 20'hF_FFFF;
               default: dt = 20'h0_0001;
            endcase
         end
         8: begin
            goal = 32'($urandom_range(0, 32'h1000_0000)) - 32'h0800_0000;
            dt   = 20'($urandom());
         end
         default: begin
            goal = $urandom();
            dt   = 20'($urandom_range(0, 32'h400));
         end
      endcase
      spring_move(goal, dt);
   endtask

   initial begin
      logic [31:0] hl;
      req_link.valid     = 1'b0;
      req_link.target    = '0;
      req_link.time_step = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at the reset half-life of one second: resting spring, a
      // normal frame, and the field extremes in both directions.
      spring_move(32'sh0000_0000, 20'h0_0000);
      spring_move(32'sh0001_0000, 20'h0_0444);
      spring_move(32'sh7FFF_FFFF, 20'hF_FFFF);
      spring_move(32'sh8000_0000, 20'hF_FFFF);
      spring_move(32'sh8000_0000, 20'h0_0000);
      spring_move(32'sh7FFF_FFFF, 20'h0_0001);
      spring_move(32'shFFFF_FFFF, 20'h1_0000);
      spring_move(32'sh0000_0000, 20'hF_FFFF);

      // A write to the unmapped address must not disturb the half-life.
      write_register(REG_UNMAPPED, 32'h0000_0000);
      spring_move(32'sh0005_0000, 20'h0_1000);

      // Zero half-life: the damping saturates and the spring snaps hard.
      write_register(REG_HALF_LIFE, 32'h0000_0000);
      spring_move(32'sh7FFF_FFFF, 20'hF_FFFF);
      spring_move(32'sh8000_0000, 20'h0_0444);
      spring_move(32'sh0000_0000, 20'h0_0001);

      // Largest half-life: the spring barely moves.
      write_register(REG_HALF_LIFE, 32'hFFFF_FFFF);
      spring_move(32'sh7FFF_FFFF, 20'hF_FFFF);
      spring_move(32'sh8000_0000, 20'hF_FFFF);
      spring_move(32'sh1234_5678, 20'h8_0000);

      // Random phases, each at its own half-life. The fourth phase runs with no request
      // gaps and no response stalls; in the first, the sender also stops halfway
      // until every owed response has come back.
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: hl = 32'h0001_0000;
            1: hl = 32'h0000_0000;
            2: hl = 32'hFFFF_FFFF;
            3: hl = 32'h0000_4000;
            4: hl = $urandom();
            5: hl = 32'h0000_0001;
            default: hl = $urandom_range(32'h100, 32'h8_0000);
         endcase
         req_gap_max   = (phase == 3) ? 0 : 4;
         rsp_stall_max = (phase == 3) ? 0 : 4;
         write_register(REG_HALF_LIFE, hl);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (phase == 0 && n == PHASE_ITEMS / 2) wait_drained();
            random_move();
         end
      end

      // Let everything owed arrive, then leave room for any stray beat to show up.
      wait_drained();
      repeat (SETTLE_WAIT) @(posedge clock);

      $display("Drove %0d request beats across %0d register writes; %0d responses compared.",
               items_sent, reg_writes, compared);
      $display("Half-lives covered zero, one LSB, the full range and random values.");
      if (failures == 0 && outstanding == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Failures: %0d, responses still owed: %0d", failures, outstanding);
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
